@@ sv/afs_pkg.sv @@
// afs_pkg: shared types and constants of the animation frame sampler
// no dependencies; imported by every module of the block but afs_ram
package afs_pkg;

  // fixed field widths of the stream ports
  localparam int DUR_W      = 24;
  localparam int TIME_W     = 32;
  localparam int TPOS_W     = TIME_W - 1;
  localparam int FRAME_W    = 6;
  localparam int CMD_W      = 2;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 8;
  localparam int WRAP_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_SET_ALL = 2'd2,
    CMD_SAMPLE  = 2'd3
  } cmd_t;

  typedef enum logic [WRAP_W-1:0] {
    WRAP_LOOP      = 2'd0,
    WRAP_PING_PONG = 2'd1,
    WRAP_CLAMP     = 2'd2,
    WRAP_NONE      = 2'd3
  } wrap_t;

  // classified command as it waits in the queue
  typedef struct packed {
    cmd_t              cmd;
    logic [DUR_W-1:0]  dur;
    logic [TPOS_W-1:0] tpos;   // sample time, negative times forced to zero
  } item_t;

endpackage

@@ sv/animation_frame_sampler.sv @@
// animation_frame_sampler: sprite clip frame lookup with loop, ping-pong, clamp and no-wrap
// append and clear complete in the idle state; set-all then writes one table entry a cycle
// sample: in loop or ping-pong mode a bit-serial remainder runs first, then a walk over the
//   duration table reads one entry a cycle until the frame holding the time or the last frame
//   is reached; the back end takes no new command until the current one is done
// reset (rst_n, synchronous, active low): empty table, zero clip length, loop mode
module animation_frame_sampler #(
  parameter int MAX_FRAMES    = 64,
  parameter int DURATION_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [afs_pkg::IN_DATA_W-1:0]   in_tdata,   // frame_duration [23:0], sample_time [55:24]
  input  logic [afs_pkg::CMD_W-1:0]       in_tuser,   // command [1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [afs_pkg::OUT_DATA_W-1:0]  out_tdata,  // frame_number [5:0], zero pad [7:6]
  output logic                            out_tuser,  // no_frames [0]
  input  logic                            cfg_wr_en,
  input  logic [afs_pkg::WRAP_W-1:0]      cfg_wr_data // wrap_mode [1:0]
);
  import afs_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // accept and classify
  afs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // execute
  afs_back #(
    .MAX_FRAMES    (MAX_FRAMES),
    .DURATION_BITS (DURATION_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // back end never pops an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // an empty table always reports frame zero
  a_none_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("no_frames result with nonzero frame");

  // queue only fills up after a beat was taken
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid))
    else $error("in_tready fell without an input beat");

endmodule

@@ sv/afs_ram.sv @@
// afs_ram: generic single write port, single read port ram with registered read
// no dependencies
module afs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ sv/afs_front.sv @@
// afs_front: input beat acceptance, command classification and a two-entry queue
// depends on afs_pkg
module afs_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [afs_pkg::IN_DATA_W-1:0]  in_tdata,   // frame_duration [23:0], sample_time [55:24]
  input  logic [afs_pkg::CMD_W-1:0]      in_tuser,   // command [1:0]
  output logic                           q_valid,
  output afs_pkg::item_t                 q_item,
  input  logic                           q_pop
);
  import afs_pkg::*;

  localparam int QD = 2;

  item_t            slot_r [QD];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             beat_in;
  item_t            cls;
  logic [TIME_W-1:0] t_raw;

  // classify the incoming beat
  always_comb begin
    t_raw    = in_tdata[DUR_W +: TIME_W];
    cls.cmd  = cmd_t'(in_tuser);
    cls.dur  = in_tdata[DUR_W-1:0];
    cls.tpos = t_raw[TIME_W-1] ? '0 : t_raw[TPOS_W-1:0];
  end

  assign in_tready = (cnt_r != 2'(QD));
  assign beat_in   = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = slot_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (beat_in) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (beat_in) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (beat_in && !q_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (q_pop && !beat_in) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

@@ sv/afs_mod.sv @@
// afs_mod: iterative restoring remainder, one dividend bit per cycle
// depends on afs_pkg
module afs_mod #(
  parameter int DV_W = 31
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [afs_pkg::TPOS_W-1:0] dividend,
  input  logic [DV_W-1:0]            divisor,
  output logic                       done,
  output logic [afs_pkg::TPOS_W-1:0] rem
);
  import afs_pkg::*;

  localparam int RW  = (DV_W + 1 > TPOS_W) ? DV_W + 1 : TPOS_W;
  localparam int CNW = $clog2(TPOS_W);

  logic [RW-1:0]     rem_r;
  logic [TPOS_W-1:0] dvd_r;
  logic [DV_W-1:0]   dvs_r;
  logic [CNW-1:0]    cnt_r;
  logic              run_r;
  logic              done_r;
  logic [RW-1:0]     trial;
  logic [RW-1:0]     dvs_x;

  // shifted trial remainder and widened divisor of one compare and subtract step
  always_comb begin
    trial = {rem_r[RW-2:0], dvd_r[TPOS_W-1]};
    dvs_x = RW'(dvs_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= '0;
        dvd_r <= dividend;
        dvs_r <= divisor;
        cnt_r <= CNW'(TPOS_W - 1);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= (trial >= dvs_x) ? trial - dvs_x : trial;
        dvd_r <= {dvd_r[TPOS_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  // remainder never exceeds the dividend, so the low bits hold it
  assign rem  = rem_r[TPOS_W-1:0];

endmodule

@@ sv/afs_back.sv @@
// afs_back: frame table, clip length, wrap register and command execution
// depends on afs_pkg, afs_ram, afs_mod
module afs_back #(
  parameter int MAX_FRAMES    = 64,
  parameter int DURATION_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  afs_pkg::item_t                  q_item,
  output logic                            q_pop,
  input  logic                            cfg_wr_en,
  input  logic [afs_pkg::WRAP_W-1:0]      cfg_wr_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [afs_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tuser
);
  import afs_pkg::*;

  localparam int DW    = DURATION_BITS;
  localparam int IDX_W = $clog2(MAX_FRAMES);
  localparam int TOT_W = $clog2(MAX_FRAMES + 1);
  localparam int LEN_W = DW + IDX_W;
  localparam int DV_W  = LEN_W + 1;
  localparam int XW    = (DV_W > TPOS_W) ? DV_W : TPOS_W;
  localparam logic [TOT_W-1:0] MAX_CNT = TOT_W'(MAX_FRAMES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_WALK,
    ST_FILL,
    ST_RESULT
  } state_t;

  state_t             state_r, state_nxt;
  wrap_t              wrap_r, wrap_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic [LEN_W-1:0]   clip_r, clip_nxt;
  logic [DW-1:0]      dur_r, dur_nxt;
  logic [TPOS_W-1:0]  t_r, t_nxt;
  logic [TOT_W-1:0]   idx_r, idx_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic [LEN_W-1:0]   end_r, end_nxt;
  logic [FRAME_W-1:0] res_frame_r, res_frame_nxt;
  logic               res_none_r, res_none_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic               out_none_r, out_none_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [DW-1:0]      ram_wdata;
  logic [DW-1:0]      ram_rdata;
  logic               mod_start;
  logic [DV_W-1:0]    mod_divisor;
  logic               mod_done;
  logic [TPOS_W-1:0]  mod_rem;

  logic [DW-1:0]      dur_in;
  logic [DUR_W+32-1:0] dur_ext;
  logic [XW-1:0]      clip_x, tpos_x, rem_x, span_x, t_x;
  logic [LEN_W-1:0]   end_sum;
  logic [31:0]        frame_wide;

  afs_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  afs_mod #(
    .DV_W (DV_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (q_item.tpos),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // operand forms shared by the decode and walk steps
  always_comb begin
    dur_ext    = {32'd0, q_item.dur};
    dur_in     = dur_ext[DW-1:0];
    clip_x     = XW'(clip_r);
    tpos_x     = XW'(q_item.tpos);
    rem_x      = XW'(mod_rem);
    span_x     = XW'({clip_r, 1'b0});
    t_x        = XW'(t_r);
    end_sum    = end_r + LEN_W'(ram_rdata);
    frame_wide = 32'(pend_idx_r);
  end

  // command sequencer
  always_comb begin
    state_nxt     = state_r;
    wrap_nxt      = wrap_r;
    total_nxt     = total_r;
    clip_nxt      = clip_r;
    dur_nxt       = dur_r;
    t_nxt         = t_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    end_nxt       = end_r;
    res_frame_nxt = res_frame_r;
    res_none_nxt  = res_none_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_frame_nxt = out_frame_r;
    out_none_nxt  = out_none_r;
    ram_we        = 1'b0;
    ram_waddr     = total_r[IDX_W-1:0];
    ram_wdata     = dur_in;
    mod_start     = 1'b0;
    mod_divisor   = (wrap_r == WRAP_PING_PONG) ? {clip_r, 1'b0} : {1'b0, clip_r};
    q_pop         = 1'b0;

    if (cfg_wr_en) begin
      wrap_nxt = wrap_t'(cfg_wr_data);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.cmd)
            CMD_APPEND: begin
              if (total_r < MAX_CNT) begin
                ram_we    = 1'b1;
                total_nxt = total_r + 1'b1;
                clip_nxt  = clip_r + LEN_W'(dur_in);
              end
            end
            CMD_CLEAR: begin
              total_nxt = '0;
              clip_nxt  = '0;
            end
            CMD_SET_ALL: begin
              if (total_r != '0) begin
                dur_nxt   = dur_in;
                clip_nxt  = '0;
                idx_nxt   = '0;
                state_nxt = ST_FILL;
              end
            end
            CMD_SAMPLE: begin
              idx_nxt  = '0;
              pend_nxt = 1'b0;
              end_nxt  = '0;
              if (total_r == '0) begin
                res_frame_nxt = '0;
                res_none_nxt  = 1'b1;
                state_nxt     = ST_RESULT;
              end else if ((wrap_r == WRAP_LOOP || wrap_r == WRAP_PING_PONG)
                           && clip_r != '0) begin
                mod_start = 1'b1;
                state_nxt = ST_DIV;
              end else if (wrap_r == WRAP_CLAMP && clip_x < tpos_x) begin
                t_nxt     = TPOS_W'(clip_x);
                state_nxt = ST_WALK;
              end else begin
                t_nxt     = q_item.tpos;
                state_nxt = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          // ping-pong folds the second half of the span back
          if (wrap_r == WRAP_PING_PONG && rem_x > clip_x) begin
            t_nxt = TPOS_W'(span_x - rem_x);
          end else begin
            t_nxt = mod_rem;
          end
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        // issue one table read a cycle, check the one that returns
        if (idx_r < total_r) begin
          idx_nxt      = idx_r + 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[IDX_W-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          end_nxt = end_sum;
          if (t_x <= XW'(end_sum) || TOT_W'(pend_idx_r) == total_r - 1'b1) begin
            res_frame_nxt = frame_wide[FRAME_W-1:0];
            res_none_nxt  = 1'b0;
            state_nxt     = ST_RESULT;
          end
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[IDX_W-1:0];
        ram_wdata = dur_r;
        clip_nxt  = clip_r + LEN_W'(dur_r);
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == total_r - 1'b1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_frame_nxt = res_frame_r;
          out_none_nxt  = res_none_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wrap_r      <= WRAP_LOOP;
      total_r     <= '0;
      clip_r      <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wrap_r      <= wrap_nxt;
      total_r     <= total_nxt;
      clip_r      <= clip_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dur_r       <= dur_nxt;
    t_r         <= t_nxt;
    pend_idx_r  <= pend_idx_nxt;
    end_r       <= end_nxt;
    res_frame_r <= res_frame_nxt;
    res_none_r  <= res_none_nxt;
    out_frame_r <= out_frame_nxt;
    out_none_r  <= out_none_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_frame_r);
  assign out_tuser  = out_none_r;

endmodule
